/* sv/swdc_pkg.sv */
`default_nettype none
package swdc_pkg;

  // Fixed field widths of the request and response items
  localparam int POS_W    = 11;
  localparam int VAL_IN_W = 16;
  localparam int CNT_W    = 12;

  // Defaults for the top-level parameters
  localparam int MAX_ELEMENTS_DEF = 1024;
  localparam int VALUE_BITS_DEF   = 16;

  // Operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Controller -> datapath
  typedef struct packed {
    logic clear;     // zero one occurrence-count entry
    logic load;      // load request accepted
    logic query;     // query request accepted
    logic step;      // move one window end, read its element
    logic cnt_rd;    // read occurrence count of that element
    logic cnt_upd;   // write back count, update distinct total
    logic result;    // load the response register
  } swdc_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic clear_done;
    logic query_bad;
    logic window_done;
    logic out_busy;
  } swdc_status_t;

endpackage
`default_nettype wire

/* sv/swdc_req_if.sv */
`default_nettype none
interface swdc_req_if
  import swdc_pkg::*;
;
  logic                valid;
  logic                ready;
  logic                operation;
  logic [POS_W-1:0]    position;
  logic [POS_W-1:0]    right_end;
  logic [VAL_IN_W-1:0] element_value;

  modport source (output valid, output operation, output position, output right_end,
                  output element_value, input ready);
  modport sink   (input valid, input operation, input position, input right_end,
                  input element_value, output ready);
endinterface
`default_nettype wire

/* sv/swdc_rsp_if.sv */
`default_nettype none
interface swdc_rsp_if
  import swdc_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] distinct_count;
  logic             query_error;

  modport source (output valid, output distinct_count, output query_error, input ready);
  modport sink   (input valid, input distinct_count, input query_error, output ready);
endinterface
`default_nettype wire

/* sv/swdc_ctrl.sv */
`default_nettype none
module swdc_ctrl
  import swdc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         req_valid,
  input  wire logic         operation,
  input  wire swdc_status_t status,
  output swdc_cmd_t         cmd,
  output logic              req_ready
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_PLAN  = 6'b000100,
    S_CNT   = 6'b001000,
    S_UPD   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          if (operation == OP_QUERY) begin
            cmd.query  = 1'b1;
            state_next = S_PLAN;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      S_PLAN: begin
        if (status.query_bad || status.window_done) begin
          state_next = S_DONE;
        end else begin
          cmd.step   = 1'b1;
          state_next = S_CNT;
        end
      end
      S_CNT: begin
        cmd.cnt_rd = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.cnt_upd = 1'b1;
        state_next  = S_PLAN;
      end
      S_DONE: begin
        if (!status.out_busy) begin
          cmd.result = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule
`default_nettype wire

/* sv/swdc_dpath.sv */
`default_nettype none
module swdc_dpath
  import swdc_pkg::*;
#(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
  parameter int VALUE_BITS   = VALUE_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire swdc_cmd_t           cmd,
  output swdc_status_t             status,
  input  wire logic [POS_W-1:0]    position,
  input  wire logic [POS_W-1:0]    right_end,
  input  wire logic [VAL_IN_W-1:0] element_value,
  input  wire logic                out_ready,
  output logic                     out_valid,
  output logic [POS_W-1:0]         distinct_count,
  output logic                     query_error
);

  localparam int ADDR_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int VSPAN  = 1 << VALUE_BITS;

  // Element store: written by loads, read one element per window step
  logic [VALUE_BITS-1:0] elem_mem [MAX_ELEMENTS];
  // Occurrence count per value
  logic [CNT_W-1:0]      cnt_mem  [VSPAN];

  logic [VALUE_BITS-1:0] clr_idx;
  logic [POS_W-1:0]      window_left;
  logic [POS_W-1:0]      window_right;
  logic [POS_W-1:0]      running_distinct;
  logic                  queries_started;
  logic [POS_W-1:0]      q_left;
  logic [POS_W-1:0]      q_right;
  logic                  q_bad;
  logic [VALUE_BITS-1:0] elem_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  step_add_q;

  logic [POS_W-1:0]      window_left_next;
  logic [POS_W-1:0]      window_right_next;
  logic [POS_W-1:0]      step_pos;
  logic                  step_add;
  logic                  no_move;
  logic [ADDR_W-1:0]     step_addr;
  logic [ADDR_W-1:0]     load_addr;
  logic                  load_ok;
  logic                  bad_in;
  logic [CNT_W-1:0]      cnt_new;
  logic                  cnt_write;
  logic [POS_W-1:0]      running_distinct_next;

  // Widen first (right then left), then narrow (left then right)
  always_comb begin
    window_left_next  = window_left;
    window_right_next = window_right;
    step_pos          = '0;
    step_add          = 1'b0;
    no_move           = 1'b0;
    if (window_right < q_right) begin
      window_right_next = window_right + POS_W'(1);
      step_pos          = window_right_next;
      step_add          = 1'b1;
    end else if (window_left > q_left) begin
      window_left_next = window_left - POS_W'(1);
      step_pos         = window_left_next;
      step_add         = 1'b1;
    end else if (window_left < q_left) begin
      window_left_next = window_left + POS_W'(1);
      step_pos         = window_left;
    end else if (window_right > q_right) begin
      window_right_next = window_right - POS_W'(1);
      step_pos          = window_right;
    end else begin
      no_move = 1'b1;
    end
  end

  assign step_addr = ADDR_W'(step_pos - POS_W'(1));
  assign load_addr = ADDR_W'(position - POS_W'(1));
  assign load_ok   = !queries_started && (position != '0) &&
                     (32'(position) <= 32'(MAX_ELEMENTS));
  assign bad_in    = (position == '0) || (position > right_end) ||
                     (32'(right_end) > 32'(MAX_ELEMENTS));

  // Count update for the element under the current step
  always_comb begin
    cnt_new               = cnt_q;
    cnt_write             = 1'b0;
    running_distinct_next = running_distinct;
    if (step_add_q) begin
      cnt_new   = cnt_q + CNT_W'(1);
      cnt_write = 1'b1;
      if (cnt_q == '0) begin
        running_distinct_next = running_distinct + POS_W'(1);
      end
    end else if (cnt_q != '0) begin
      cnt_new   = cnt_q - CNT_W'(1);
      cnt_write = 1'b1;
      if ((cnt_q == CNT_W'(1)) && (running_distinct != '0)) begin
        running_distinct_next = running_distinct - POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && load_ok) begin
      elem_mem[load_addr] <= VALUE_BITS'(element_value);
    end
    if (cmd.step) begin
      elem_q <= elem_mem[step_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      cnt_mem[clr_idx] <= '0;
    end else if (cmd.cnt_upd && cnt_write) begin
      cnt_mem[elem_q] <= cnt_new;
    end
    if (cmd.cnt_rd) begin
      cnt_q <= cnt_mem[elem_q];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.query) begin
      q_left  <= position;
      q_right <= right_end;
      q_bad   <= bad_in;
    end
    if (cmd.step) begin
      step_add_q <= step_add;
    end
    if (cmd.result) begin
      distinct_count <= q_bad ? '0 : running_distinct;
      query_error    <= q_bad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx          <= '0;
      window_left      <= POS_W'(1);
      window_right     <= '0;
      running_distinct <= '0;
      queries_started  <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (cmd.clear) begin
        clr_idx <= clr_idx + VALUE_BITS'(1);
      end
      if (cmd.query) begin
        queries_started <= 1'b1;
      end
      if (cmd.step) begin
        window_left  <= window_left_next;
        window_right <= window_right_next;
      end
      if (cmd.cnt_upd) begin
        running_distinct <= running_distinct_next;
      end
      if (cmd.result) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.clear_done  = (clr_idx == '1);
  assign status.query_bad   = q_bad;
  assign status.window_done = no_move;
  assign status.out_busy    = out_valid && !out_ready;

  // Window is never less than empty: the left end is at most one past the right end
  a_window_order: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, window_left} <= ({1'b0, window_right} + (POS_W + 1)'(1))))
    else $error("window left end passed right end");

  // Distinct total fits the window; a removal whose count update (S_CNT, S_UPD) is
  // still pending may leave it one above the already shrunk length
  a_distinct_fits: assert property (@(posedge clk) disable iff (rst)
    ((POS_W + 1)'(running_distinct) <=
     (({1'b0, window_right} + (POS_W + 1)'(2)) - {1'b0, window_left})))
    else $error("distinct total larger than window");

  // A loaded response is presented on the next cycle
  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    cmd.result |=> out_valid)
    else $error("response register not valid after load");

endmodule
`default_nettype wire

/* sv/sliding_window_distinct_counter_top.sv */
// Load request: taken while idle, no response.
// Query request: the window is moved to the new ends one single-end move at a time;
//   each move passes S_PLAN (element read), S_CNT (count read), S_UPD (count write). A
//   rejected query skips the walk. The next request is taken once S_DONE loaded the response.
// Reset (synchronous, active high): clears window and control, then a clearing pass
//   zeroes all 2^VALUE_BITS occurrence counts; ready stays low meanwhile.
`default_nettype none
module sliding_window_distinct_counter_top
  import swdc_pkg::*;
#(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
  parameter int VALUE_BITS   = VALUE_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  swdc_req_if.sink    req,
  swdc_rsp_if.source  rsp
);

  // Controller and datapath talk only through these two groups
  swdc_cmd_t    cmd;
  swdc_status_t status;

  // Sequencer: clearing pass, request intake, window walk, response hand-off
  swdc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .operation (req.operation),
    .status    (status),
    .cmd       (cmd),
    .req_ready (req.ready)
  );

  // Element store, per-value occurrence counts, window ends, response register.
  // The response register decouples the two sides: a new request is taken while a
  // finished response still waits for its sink.
  swdc_dpath #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .VALUE_BITS   (VALUE_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .position       (req.position),
    .right_end      (req.right_end),
    .element_value  (req.element_value),
    .out_ready      (rsp.ready),
    .out_valid      (rsp.valid),
    .distinct_count (rsp.distinct_count),
    .query_error    (rsp.query_error)
  );

endmodule
`default_nettype wire
